/* design/assert_macros.svh */
// Assertion macros for the RTL, included by heap_region_write_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

// The condition must hold in every cycle out of reset.
`define ASSERT_ALWAYS(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("%m: invariant check failed");

`endif

/* design/hrwc_pkg.sv */
package hrwc_pkg;

  // Default sizing of the region table and the address path.
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int ADDR_WIDTH_DEF  = 48;

  // Stack floor after reset, cut down to the address width where it is used.
  localparam logic [63:0] STACK_FLOOR_RST = 64'h0000_7000_0000_0000;

  // Only instructions with this operand count are checked.
  localparam logic [3:0] CHECK_OPC = 4'd2;

  // Request types.
  localparam logic [1:0] REQ_SIZE  = 2'd0;
  localparam logic [1:0] REQ_ALLOC = 2'd1;
  localparam logic [1:0] REQ_FREE  = 2'd2;
  localparam logic [1:0] REQ_WRITE = 2'd3;

  // Verdict codes.
  localparam logic [2:0] V_DONE     = 3'd0;
  localparam logic [2:0] V_SKIP     = 3'd1;
  localparam logic [2:0] V_IMAGE    = 3'd2;
  localparam logic [2:0] V_LIVE     = 3'd3;
  localparam logic [2:0] V_UAF      = 3'd4;
  localparam logic [2:0] V_STACK    = 3'd5;
  localparam logic [2:0] V_OVERFLOW = 3'd6;
  localparam logic [2:0] V_FULL     = 3'd7;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_LOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HIGH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STACK_FLOOR = 2'd2;

endpackage

/* design/heap_region_write_checker.sv */
// Heap region write checker.
// Items enter on start/busy: an item is taken at a clock edge where start is
// high and busy is low, with in_req_type, in_address, in_amount and
// in_operand_count on their ports. Every item gives exactly one result,
// shown for one cycle with out_strobe high, carrying out_verdict and
// out_region_base. The receiver cannot stall, so results are never held.
// Size requests, zero allocation returns, skipped writes and image-window
// hits give their result in the cycle after the item is taken. Any other item
// searches the region table newest entry first, one memory read per cycle:
// the result comes after the first matching entry is examined, or after a
// final no-match step once all entries are examined without a match. The
// table memory's single read port sets the pace of the search. busy is low
// again in the cycle the result is shown, so the next item may enter then.
// The configuration port (cfg_we, cfg_index, cfg_data) writes one register
// per edge and is to be used only while the block is idle; the block itself
// does not enforce this. A synchronous reset clears the entry count and the
// latched size and sets the registers to their reset values; table contents
// are not cleared, since only entries below the count are ever used.
module heap_region_write_checker #(
  parameter int TABLE_DEPTH = hrwc_pkg::TABLE_DEPTH_DEF,
  parameter int ADDR_WIDTH  = hrwc_pkg::ADDR_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration port.
  input  logic                           cfg_we,
  input  logic [hrwc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_WIDTH-1:0]          cfg_data,
  // Input channel.
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_req_type,
  input  logic [ADDR_WIDTH-1:0]          in_address,
  input  logic [ADDR_WIDTH-1:0]          in_amount,
  input  logic [3:0]                     in_operand_count,
  // Result channel.
  output logic                           out_strobe,
  output logic [2:0]                     out_verdict,
  output logic [ADDR_WIDTH-1:0]          out_region_base
);

  import hrwc_pkg::*;

  `include "assert_macros.svh"

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int ENT_W = 2 * ADDR_WIDTH + 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

  // Controller states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MISS = 2'd2;

  // Control and item registers.
  logic [1:0]            state_r,   state_nxt;
  logic [1:0]            type_r,    type_nxt;
  logic [ADDR_WIDTH-1:0] addr_r,    addr_nxt;
  logic [IDX_W-1:0]      chk_idx_r, chk_idx_nxt;
  logic [CNT_W-1:0]      count_r,   count_nxt;
  logic [ADDR_WIDTH-1:0] pend_r,    pend_nxt;

  // Configuration registers.
  logic [ADDR_WIDTH-1:0] image_low_r;
  logic [ADDR_WIDTH-1:0] image_high_r;
  logic [ADDR_WIDTH-1:0] stack_floor_r;

  // Result registers.
  logic                  out_strobe_r;
  logic [2:0]            out_verdict_r;
  logic [ADDR_WIDTH-1:0] out_base_r;

  // Result of the current cycle, registered onto the ports.
  logic                  res_vld;
  logic [2:0]            res_verdict;
  logic [ADDR_WIDTH-1:0] res_base;

  // Table memory: each entry is {base, size, freed}.
  logic [ENT_W-1:0]      mem [TABLE_DEPTH];
  logic [IDX_W-1:0]      rd_addr;
  logic [ENT_W-1:0]      rd_data_r;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [ENT_W-1:0]      wr_data;

  // Fields of the entry read last cycle.
  logic [ADDR_WIDTH-1:0] e_start;
  logic [ADDR_WIDTH-1:0] e_len;
  logic                  e_freed;
  logic [ADDR_WIDTH-1:0] e_offset;
  logic                  base_hit;
  logic                  range_hit;
  logic                  hit;
  logic [CNT_W-1:0]      cnt_m1;
  logic                  image_hit;

  assign e_start  = rd_data_r[ENT_W-1 -: ADDR_WIDTH];
  assign e_len    = rd_data_r[ADDR_WIDTH:1];
  assign e_freed  = rd_data_r[0];
  assign e_offset = addr_r - e_start;

  // Base match for allocations and frees, range match for write checks.
  assign base_hit  = (e_start == addr_r);
  assign range_hit = (addr_r >= e_start) && (e_offset < e_len);
  assign hit       = (type_r == REQ_WRITE) ? range_hit : base_hit;

  assign cnt_m1    = count_r - 1'b1;
  assign image_hit = (in_address >= image_low_r) && (in_address < image_high_r);

  // Memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Sequencer: accept an item, answer it at once or scan the table newest first, then write back allocations and frees.
  always_comb begin
    state_nxt   = state_r;
    type_nxt    = type_r;
    addr_nxt    = addr_r;
    chk_idx_nxt = chk_idx_r;
    count_nxt   = count_r;
    pend_nxt    = pend_r;
    res_vld     = 1'b0;
    res_verdict = V_DONE;
    res_base    = '0;
    wr_en       = 1'b0;
    wr_addr     = chk_idx_r;
    wr_data     = {e_start, pend_r, 1'b0};
    rd_addr     = chk_idx_r - 1'b1;

    case (state_r)
      S_IDLE: begin
        rd_addr = cnt_m1[IDX_W-1:0];
        if (start) begin
          type_nxt    = in_req_type;
          addr_nxt    = in_address;
          chk_idx_nxt = cnt_m1[IDX_W-1:0];
          case (in_req_type)
            REQ_SIZE: begin
              pend_nxt = in_amount;
              res_vld  = 1'b1;
            end
            REQ_ALLOC: begin
              if (in_address == '0) begin
                res_vld     = 1'b1;
                res_verdict = V_SKIP;
              end else begin
                state_nxt = (count_r == '0) ? S_MISS : S_SCAN;
              end
            end
            REQ_FREE: begin
              state_nxt = (count_r == '0) ? S_MISS : S_SCAN;
            end
            default: begin
              if (in_operand_count != CHECK_OPC) begin
                res_vld     = 1'b1;
                res_verdict = V_SKIP;
              end else if (image_hit) begin
                res_vld     = 1'b1;
                res_verdict = V_IMAGE;
              end else begin
                state_nxt = (count_r == '0) ? S_MISS : S_SCAN;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          res_vld   = 1'b1;
          state_nxt = S_IDLE;
          case (type_r)
            REQ_ALLOC: begin
              // Revive the entry with the latched size.
              wr_en   = 1'b1;
              wr_data = {e_start, pend_r, 1'b0};
            end
            REQ_FREE: begin
              wr_en   = 1'b1;
              wr_data = {e_start, e_len, 1'b1};
            end
            REQ_WRITE: begin
              res_verdict = e_freed ? V_UAF : V_LIVE;
              res_base    = e_start;
            end
            default: begin
              res_verdict = V_DONE;
            end
          endcase
        end else if (chk_idx_r == '0) begin
          state_nxt = S_MISS;
        end else begin
          chk_idx_nxt = chk_idx_r - 1'b1;
        end
      end

      S_MISS: begin
        // Nothing matched in the table.
        res_vld   = 1'b1;
        state_nxt = S_IDLE;
        case (type_r)
          REQ_ALLOC: begin
            if (count_r == CNT_FULL) begin
              res_verdict = V_FULL;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = count_r[IDX_W-1:0];
              wr_data   = {addr_r, pend_r, 1'b0};
              count_nxt = count_r + 1'b1;
            end
          end
          REQ_WRITE: begin
            res_verdict = (addr_r > stack_floor_r) ? V_STACK : V_OVERFLOW;
          end
          default: begin
            res_verdict = V_DONE;
          end
        endcase
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      pend_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= res_vld;
    end
  end

  // Item and result payload.
  always_ff @(posedge clk) begin
    type_r        <= type_nxt;
    addr_r        <= addr_nxt;
    chk_idx_r     <= chk_idx_nxt;
    out_verdict_r <= res_verdict;
    out_base_r    <= res_base;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_low_r   <= '0;
      image_high_r  <= '0;
      stack_floor_r <= STACK_FLOOR_RST[ADDR_WIDTH-1:0];
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_LOW:   image_low_r   <= cfg_data;
        CFG_IMAGE_HIGH:  image_high_r  <= cfg_data;
        CFG_STACK_FLOOR: stack_floor_r <= cfg_data;
        default:         ;
      endcase
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_strobe      = out_strobe_r;
  assign out_verdict     = out_verdict_r;
  assign out_region_base = out_base_r;

  // The table never holds more entries than it has room for.
  `ASSERT_ALWAYS(a_count_bound, clk, rst_n, (count_r <= CNT_FULL))
  // An accepted item either gives its result next cycle or starts a search.
  `ASSERT_NEXT(a_accept_progress, clk, rst_n, (start && !busy), (busy || out_strobe_r))
  // The entry count only ever grows by one.
  `ASSERT_IMPLIES(a_count_step, clk, rst_n, ($past(rst_n) && (count_r != $past(count_r))), (count_r == $past(count_r) + 1'b1))

endmodule

/* verif/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hrwc_pkg::*;

  localparam int AW            = ADDR_WIDTH_DEF;
  localparam int DEPTH         = TABLE_DEPTH_DEF;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int PHASES        = 6;
  localparam int QUIET_PHASE   = 4;
  localparam int SEARCH_CYCLES = DEPTH + 2;
  localparam int CYCLE_LIMIT   = 1_000_000;

  typedef logic [AW-1:0] addr_t;

  localparam addr_t ADDR_MAX = '1;

  typedef struct packed {
    logic [2:0] verdict;
    addr_t      base;
  } outcome_t;

  typedef struct packed {
    logic [1:0] kind;
    addr_t      addr;
    addr_t      amount;
    logic [3:0] opc;
    logic       typed;
    outcome_t   want;
  } step_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_IMAGE_LOW;
  addr_t                cfg_data = '0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           in_req_type = REQ_SIZE;
  addr_t                in_address = '0;
  addr_t                in_amount = '0;
  logic [3:0]           in_operand_count = '0;
  logic                 out_strobe;
  logic [2:0]           out_verdict;
  addr_t                out_region_base;

  // Shadow of the region table, the latched size and the registers.
  addr_t heap_base [DEPTH];
  addr_t heap_len [DEPTH];
  logic  heap_freed [DEPTH];
  int    heap_used = 0;
  addr_t size_latch = '0;
  addr_t win_low = '0;
  addr_t win_high = '0;
  addr_t floor_addr = STACK_FLOOR_RST[AW-1:0];

  outcome_t expected_results [$];
  int       mismatches = 0;
  int       cycles = 0;

  heap_region_write_checker uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_address       (in_address),
    .in_amount        (in_amount),
    .in_operand_count (in_operand_count),
    .out_strobe       (out_strobe),
    .out_verdict      (out_verdict),
    .out_region_base  (out_region_base)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Newest table entry whose base equals the address, or -1.
  function automatic int newest_with_base(addr_t addr);
    int k;
    for (k = heap_used - 1; k >= 0; k--) begin
      if (heap_base[k] == addr) return k;
    end
    return -1;
  endfunction

  // Applies one item to the shadow state and returns the verdict it earns.
  function automatic outcome_t judge_request(logic [1:0] kind, addr_t addr, addr_t amount,
                                             logic [3:0] opc);
    outcome_t res;
    int       hit;
    int       k;
    res.verdict = V_DONE;
    res.base = '0;
    hit = -1;
    case (kind)
      REQ_SIZE: size_latch = amount;
      REQ_ALLOC: begin
        if (addr == '0) begin
          res.verdict = V_SKIP;
        end else begin
          hit = newest_with_base(addr);
          if (hit >= 0) begin
            heap_len[hit] = size_latch;
            heap_freed[hit] = 1'b0;
          end else if (heap_used >= DEPTH) begin
            res.verdict = V_FULL;
          end else begin
            heap_base[heap_used] = addr;
            heap_len[heap_used] = size_latch;
            heap_freed[heap_used] = 1'b0;
            heap_used++;
          end
        end
      end
      REQ_FREE: begin
        hit = newest_with_base(addr);
        if (hit >= 0) heap_freed[hit] = 1'b1;
      end
      default: begin
        if (opc != CHECK_OPC) begin
          res.verdict = V_SKIP;
        end else if (addr >= win_low && addr < win_high) begin
          res.verdict = V_IMAGE;
        end else begin
          // Newest region first; a zero-size region never matches.
          for (k = heap_used - 1; k >= 0; k--) begin
            if (hit < 0 && addr >= heap_base[k] && (addr - heap_base[k]) < heap_len[k])
              hit = k;
          end
          if (hit >= 0) begin
            res.verdict = heap_freed[hit] ? V_UAF : V_LIVE;
            res.base = heap_base[hit];
          end else begin
            res.verdict = (addr > floor_addr) ? V_STACK : V_OVERFLOW;
          end
        end
      end
    endcase
    return res;
  endfunction

  function automatic addr_t rand_addr();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[AW-1:0];
  endfunction

  // A base that is most likely not in the table yet.
  function automatic addr_t fresh_base();
    if ($urandom_range(0, 1) == 0) return rand_addr() & ~addr_t'(15);
    return addr_t'($urandom()) & ~addr_t'(15);
  endfunction

  function automatic step_t plan_row(logic [1:0] kind, addr_t addr, addr_t amount,
                                     logic [3:0] opc, logic typed, logic [2:0] verdict,
                                     addr_t base);
    step_t s;
    s.kind = kind;
    s.addr = addr;
    s.amount = amount;
    s.opc = opc;
    s.typed = typed;
    s.want.verdict = verdict;
    s.want.base = base;
    return s;
  endfunction

  // Presents one item, optionally after a random gap, and records its expected result
  // once the block has taken it.
  task automatic issue(step_t s, bit gaps, output outcome_t res);
    if (gaps && $urandom_range(0, 99) < 9) begin
      start <= 1'b0;
      repeat ($urandom_range(1, SEARCH_CYCLES + 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= s.kind;
    in_address <= s.addr;
    in_amount <= s.amount;
    in_operand_count <= s.opc;
    @(posedge clk);
    while (busy) @(posedge clk);
    res = judge_request(s.kind, s.addr, s.amount, s.opc);
    expected_results.insert(expected_results.size(), s.typed ? s.want : res);
  endtask

  // Stops sending and waits until every expected result has arrived.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges; only called while idle.
  task automatic load_config(addr_t low, addr_t high, addr_t floor_val);
    cfg_we <= 1'b1;
    cfg_index <= CFG_IMAGE_LOW;
    cfg_data <= low;
    @(posedge clk);
    cfg_index <= CFG_IMAGE_HIGH;
    cfg_data <= high;
    @(posedge clk);
    cfg_index <= CFG_STACK_FLOOR;
    cfg_data <= floor_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_low = low;
    win_high = high;
    floor_addr = floor_val;
  endtask

  // One random action: mostly allocation pairs, frees of known bases and writes aimed
  // at region edges, the window and the stack floor, with some plain noise.
  task automatic random_action(bit gaps, inout int counted);
    step_t    s;
    outcome_t res;
    int       pick;
    int       k;
    addr_t    base_pick;
    addr_t    len_pick;
    pick = $urandom_range(0, 99);
    s.kind = REQ_WRITE;
    s.addr = rand_addr();
    s.amount = rand_addr();
    s.opc = 4'($urandom_range(0, 15));
    s.typed = 1'b0;
    s.want = '0;
    if (pick < 30) begin
      s.kind = REQ_SIZE;
      case ($urandom_range(0, 9))
        0: s.amount = '0;
        1: s.amount = rand_addr();
        2: s.amount = addr_t'($urandom_range(1, 1 << 20));
        default: s.amount = addr_t'($urandom_range(1, 4096));
      endcase
      issue(s, gaps, res);
      if (res.verdict != V_SKIP) counted++;
      s.kind = REQ_ALLOC;
      s.amount = rand_addr();
      if (heap_used > 0 && $urandom_range(0, 99) < 35)
        s.addr = heap_base[$urandom_range(0, heap_used - 1)];
      else
        s.addr = fresh_base();
    end else if (pick < 42) begin
      s.kind = REQ_FREE;
      if (heap_used > 0 && $urandom_range(0, 9) != 0)
        s.addr = heap_base[$urandom_range(0, heap_used - 1)];
      else
        s.addr = fresh_base();
    end else if (pick < 90) begin
      s.kind = REQ_WRITE;
      if ($urandom_range(0, 9) != 0) s.opc = CHECK_OPC;
      pick = $urandom_range(0, 9);
      if (pick <= 5 && heap_used > 0) begin
        k = $urandom_range(0, heap_used - 1);
        base_pick = heap_base[k];
        len_pick = heap_len[k];
        case ($urandom_range(0, 4))
          0: s.addr = base_pick;
          1: s.addr = base_pick + len_pick - 1;
          2: s.addr = base_pick + len_pick;
          3: s.addr = base_pick - 1;
          default: s.addr = base_pick + ((len_pick == '0) ? '0 : rand_addr() % len_pick);
        endcase
      end else if (pick == 6) begin
        case ($urandom_range(0, 3))
          0: s.addr = win_low;
          1: s.addr = win_low - 1;
          2: s.addr = win_high - 1;
          default: s.addr = win_high;
        endcase
      end else if (pick == 7) begin
        s.addr = floor_addr + addr_t'($urandom_range(0, 2)) - 1;
      end
    end else begin
      // Noise: any request type, stray allocations and zero bases included.
      s.kind = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 9) < 3) s.addr = '0;
    end
    issue(s, gaps, res);
    if (res.verdict != V_SKIP) counted++;
  endtask

  // Result checker: every strobed result must match the oldest expectation.
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, verdict %0d base %h", $time, out_verdict,
                 out_region_base);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_verdict !== want.verdict) begin
          $display("%0t: verdict expected %0d, got %0d", $time, want.verdict, out_verdict);
          mismatches++;
        end
        if (out_region_base !== want.base) begin
          $display("%0t: region base expected %h, got %h", $time, want.base,
                   out_region_base);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    step_t    directed_plan [$];
    outcome_t res;
    addr_t    lo;
    addr_t    hi;
    addr_t    fl;
    int       phase;
    int       counted;

    // Directed items at the reset settings: empty image window, default stack floor.
    directed_plan = '{
      plan_row(REQ_WRITE, 48'h0000_0000_1000, '0, CHECK_OPC, 1'b1, V_OVERFLOW, '0),
      plan_row(REQ_WRITE, 48'h7000_0000_0001, '0, CHECK_OPC, 1'b1, V_STACK, '0),
      plan_row(REQ_WRITE, 48'h7000_0000_0000, '0, CHECK_OPC, 1'b1, V_OVERFLOW, '0),
      plan_row(REQ_WRITE, ADDR_MAX, ADDR_MAX, CHECK_OPC, 1'b1, V_STACK, '0),
      plan_row(REQ_WRITE, '0, '0, CHECK_OPC, 1'b1, V_OVERFLOW, '0),
      plan_row(REQ_WRITE, 48'h0000_0000_1000, '0, 4'h0, 1'b1, V_SKIP, '0),
      plan_row(REQ_WRITE, 48'h0000_0000_1000, '0, 4'hF, 1'b1, V_SKIP, '0),
      plan_row(REQ_SIZE, '0, 48'h0000_0000_0100, 4'h0, 1'b1, V_DONE, '0),
      plan_row(REQ_ALLOC, '0, ADDR_MAX, 4'hF, 1'b1, V_SKIP, '0),
      plan_row(REQ_ALLOC, 48'h0000_0001_0000, '0, 4'h0, 1'b1, V_DONE, '0),
      plan_row(REQ_WRITE, 48'h0000_0001_0000, '0, CHECK_OPC, 1'b1, V_LIVE,
               48'h0000_0001_0000),
      plan_row(REQ_WRITE, 48'h0000_0001_00FF, '0, CHECK_OPC, 1'b1, V_LIVE,
               48'h0000_0001_0000),
      plan_row(REQ_WRITE, 48'h0000_0001_0100, '0, CHECK_OPC, 1'b1, V_OVERFLOW, '0),
      plan_row(REQ_WRITE, 48'h0000_0000_FFFF, '0, CHECK_OPC, 1'b1, V_OVERFLOW, '0),
      plan_row(REQ_FREE, 48'h0000_0002_0000, '0, 4'h0, 1'b1, V_DONE, '0),
      plan_row(REQ_FREE, 48'h0000_0001_0000, '0, 4'h0, 1'b1, V_DONE, '0),
      plan_row(REQ_WRITE, 48'h0000_0001_0080, '0, CHECK_OPC, 1'b1, V_UAF,
               48'h0000_0001_0000),
      plan_row(REQ_SIZE, '0, '0, 4'h0, 1'b1, V_DONE, '0),
      plan_row(REQ_ALLOC, 48'h0000_0002_0000, '0, 4'h0, 1'b1, V_DONE, '0),
      plan_row(REQ_WRITE, 48'h0000_0002_0000, '0, CHECK_OPC, 1'b1, V_OVERFLOW, '0),
      plan_row(REQ_SIZE, '0, ADDR_MAX, 4'h0, 1'b1, V_DONE, '0),
      plan_row(REQ_ALLOC, 48'h0000_0001_0000, '0, 4'h0, 1'b1, V_DONE, '0),
      plan_row(REQ_WRITE, 48'h0000_0002_0000, '0, CHECK_OPC, 1'b0, V_DONE, '0),
      plan_row(REQ_WRITE, ADDR_MAX, '0, CHECK_OPC, 1'b0, V_DONE, '0),
      plan_row(REQ_FREE, '0, ADDR_MAX, 4'hF, 1'b1, V_DONE, '0)
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i]) issue(directed_plan[i], 1'b1, res);

    // Random phases, each under its own register settings, extremes among them.
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          lo = 48'h0000_0040_0000;
          hi = 48'h0000_0080_0000;
          fl = STACK_FLOOR_RST[AW-1:0];
        end
        1: begin
          lo = '0;
          hi = ADDR_MAX;
          fl = ADDR_MAX;
        end
        2: begin
          lo = ADDR_MAX;
          hi = '0;
          fl = '0;
        end
        3: begin
          lo = rand_addr();
          hi = lo;
          fl = rand_addr();
        end
        default: begin
          lo = rand_addr();
          hi = lo + addr_t'($urandom());
          fl = rand_addr();
        end
      endcase
      drain();
      load_config(lo, hi, fl);
      counted = 0;
      while (counted < RANDOM_ITEMS / PHASES) random_action(phase != QUIET_PHASE, counted);
    end

    drain();
    repeat (SEARCH_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* heap_region_write_checker.f */
+incdir+design
design/hrwc_pkg.sv
design/heap_region_write_checker.sv
verif/tb_top.sv
